### sv/pll_synth_serial_programmer_top_assert.svh
// pll_synth_serial_programmer_top_assert.svh: assertion macros for the serial programmer.
// Uses the names clk and arst_n of the including module; nothing else is needed.
`ifndef PLL_SYNTH_SERIAL_PROGRAMMER_TOP_ASSERT_SVH
`define PLL_SYNTH_SERIAL_PROGRAMMER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define PLLSS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("pllss: assertion failed");
// A condition that, when true, forces a result at the next clock edge.
`define PLLSS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("pllss: next-cycle check failed");
`else
`define PLLSS_ASSERT(lbl, prop)
`define PLLSS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### sv/pllss_pkg.sv
// pllss_pkg.sv: types and constants of the PLL synthesizer serial programmer.
// No dependencies; every other file of the block, apart from the assertion header, uses it.
package pllss_pkg;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int A_W     = 8;
	localparam int B_W     = 12;
	localparam int CTRL_W  = 8;
	localparam int FRAME_W = 24;
	localparam int LEN_W   = 5;
	localparam int R_W     = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_CONTROL = 2'd0,
		CMD_REF_DIV = 2'd1,
		CMD_FREQ    = 2'd2,
		CMD_DIRECT  = 2'd3
	} cmd_t;

	localparam logic [CTRL_W-1:0] CTRL_RESET = 8'h6D;

	// 15000 = 8 * 1875: the value is shifted right by three, then divided by 1875
	// through a reciprocal multiply with one correction step.
	localparam int STEP_SH = 3;
	localparam int X_W     = VALUE_W - STEP_SH;
	localparam int Q_W     = 19;
	localparam int M_W     = 30;
	localparam int PROD_W  = X_W + M_W;
	localparam int RECIP_SH = 40;
	localparam int QM_W    = 30;
	localparam logic [M_W-1:0] RECIP_M = 30'd586406201;
	localparam logic [10:0] DIV_ODD = 11'd1875;

	// 64 steps make one B count: B is the quotient over 64, A the remainder.
	localparam int MOD_SH = 6;
	localparam int BQ_W   = Q_W - MOD_SH;

	localparam logic [3:0]     B_PREFIX = 4'h7;
	localparam logic [R_W-1:0] R_ENABLE = 16'h2000;
	localparam logic [R_W-1:0] R_MAX    = 16'hFFFF;
	localparam logic [B_W-1:0] B_MAX    = 12'hFFF;

	localparam logic [LEN_W-1:0] LEN_CONTROL = 5'd8;
	localparam logic [LEN_W-1:0] LEN_REF_DIV = 5'd16;
	localparam logic [LEN_W-1:0] LEN_AB      = 5'd24;

	typedef struct packed {
		cmd_t               command;
		logic [VALUE_W-1:0] value;
		logic [A_W-1:0]     a_count;
		logic [B_W-1:0]     b_count;
	} cmd_beat_t;

	typedef struct packed {
		logic [FRAME_W-1:0] bits;
		logic [LEN_W-1:0]   len;
		logic               err;
	} frame_t;

endpackage

### sv/pllss_if.sv
// pllss_if.sv: valid/ready channels of the serial programmer, command in and bits out.
// Depends on pllss_pkg for the field widths.
interface pllss_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [pllss_pkg::CMD_W-1:0]          command;
	logic [pllss_pkg::VALUE_W-1:0]        value;
	logic [pllss_pkg::A_W-1:0]            a_count;
	logic [pllss_pkg::B_W-1:0]            b_count;

	modport source (output valid, command, value, a_count, b_count, input ready);
	modport sink   (input valid, command, value, a_count, b_count, output ready);
endinterface

interface pllss_bit_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic last;
	logic range_error;

	modport source (output valid, data_bit, last, range_error, input ready);
	modport sink   (input valid, data_bit, last, range_error, output ready);
endinterface

### sv/pllss_divq.sv
// pllss_divq.sv: four-stage pipeline that divides the command value by 15000.
// Depends on pllss_pkg; the command beat travels alongside the quotient.
module pllss_divq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pllss_pkg::cmd_beat_t           in_beat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pllss_pkg::cmd_beat_t           out_beat,
	output logic [pllss_pkg::Q_W-1:0]      out_quot
);
	import pllss_pkg::*;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	cmd_beat_t         beat_s1, beat_s2, beat_s3, beat_s4;
	logic [Q_W-1:0]    qest_s2, qest_s3, quot_s4;
	logic [QM_W-1:0]   qm_s3;
	logic [X_W-1:0]    x_s1, x_s3;
	logic [PROD_W-1:0] prod;
	logic [QM_W-1:0]   qm;
	logic [QM_W-1:0]   rem;
	logic              corr;

	// A stage takes a new beat when it is empty or its beat moves on.
	assign rdy_s4   = out_ready | ~v_s4;
	assign rdy_s3   = rdy_s4 | ~v_s3;
	assign rdy_s2   = rdy_s3 | ~v_s2;
	assign rdy_s1   = rdy_s2 | ~v_s1;
	assign in_ready = rdy_s1;

	assign x_s1 = beat_s1.value[VALUE_W-1:STEP_SH];
	assign x_s3 = beat_s3.value[VALUE_W-1:STEP_SH];
	assign prod = PROD_W'(x_s1) * PROD_W'(RECIP_M);
	assign qm   = QM_W'(qest_s2) * QM_W'(DIV_ODD);
	assign rem  = QM_W'(x_s3) - qm_s3;
	assign corr = rem >= QM_W'(DIV_ODD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			beat_s1 <= in_beat;
		end
		if (rdy_s2 && v_s1) begin
			beat_s2 <= beat_s1;
			qest_s2 <= prod[RECIP_SH +: Q_W];
		end
		if (rdy_s3 && v_s2) begin
			beat_s3 <= beat_s2;
			qest_s3 <= qest_s2;
			qm_s3   <= qm;
		end
		if (rdy_s4 && v_s3) begin
			beat_s4 <= beat_s3;
			quot_s4 <= qest_s3 + Q_W'(corr);
		end
	end

	assign out_valid = v_s4;
	assign out_beat  = beat_s4;
	assign out_quot  = quot_s4;
endmodule

### sv/pllss_frame.sv
// pllss_frame.sv: pipeline stage that builds the MSB-aligned frame for one command.
// Depends on pllss_pkg; takes the quotient from pllss_divq.
module pllss_frame (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pllss_pkg::CTRL_W-1:0]   control_word,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pllss_pkg::cmd_beat_t           in_beat,
	input  logic [pllss_pkg::Q_W-1:0]      in_quot,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pllss_pkg::frame_t              out_frame
);
	import pllss_pkg::*;

	logic            v_s5;
	frame_t          frame_s5;
	frame_t          frame_d;
	logic [BQ_W-1:0] b_full;
	logic            b_over;
	logic [B_W-1:0]  b_sat;
	logic [A_W-1:0]  a_freq;
	logic            r_over;
	logic [R_W-1:0]  r_sat;

	assign b_full = in_quot[Q_W-1:MOD_SH];
	assign b_over = b_full > BQ_W'(B_MAX);
	assign b_sat  = b_over ? B_MAX : b_full[B_W-1:0];
	assign a_freq = A_W'(in_quot[MOD_SH-1:0]);
	assign r_over = |in_beat.value[VALUE_W-1:R_W];
	assign r_sat  = (r_over ? R_MAX : in_beat.value[R_W-1:0]) | R_ENABLE;

	always_comb begin
		frame_d = '0;
		case (in_beat.command)
			CMD_CONTROL: begin
				frame_d.bits = {control_word, (FRAME_W-CTRL_W)'(0)};
				frame_d.len  = LEN_CONTROL;
			end
			CMD_REF_DIV: begin
				frame_d.bits = {r_sat, (FRAME_W-R_W)'(0)};
				frame_d.len  = LEN_REF_DIV;
				frame_d.err  = r_over;
			end
			CMD_FREQ: begin
				frame_d.bits = {B_PREFIX, b_sat, a_freq};
				frame_d.len  = LEN_AB;
				frame_d.err  = b_over;
			end
			CMD_DIRECT: begin
				frame_d.bits = {B_PREFIX, in_beat.b_count, in_beat.a_count};
				frame_d.len  = LEN_AB;
			end
			default: begin
				frame_d = '0;
			end
		endcase
	end

	assign in_ready = out_ready | ~v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (in_ready) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			frame_s5 <= frame_d;
		end
	end

	assign out_valid = v_s5;
	assign out_frame = frame_s5;
endmodule

### sv/pllss_ser.sv
// pllss_ser.sv: shift register that sends one frame MSB first, one bit per beat.
// Depends on pllss_pkg, pllss_if and the assertion macro header.
module pllss_ser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pllss_pkg::frame_t    in_frame,
	pllss_bit_if.source          serial
);
	import pllss_pkg::*;
	`include "pll_synth_serial_programmer_top_assert.svh"

	logic [FRAME_W-1:0] shift_q;
	logic [LEN_W-1:0]   bits_left_q;
	logic               err_q;
	logic               out_fire;

	assign out_fire = serial.valid & serial.ready;
	// A new frame loads when the shifter is empty or its final bit leaves now.
	assign in_ready = (bits_left_q == '0) |
		((bits_left_q == LEN_W'(1)) & serial.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			bits_left_q <= '0;
			err_q       <= 1'b0;
		end else if (in_valid && in_ready) begin
			shift_q     <= in_frame.bits;
			bits_left_q <= in_frame.len;
			err_q       <= in_frame.err;
		end else if (out_fire) begin
			shift_q     <= {shift_q[FRAME_W-2:0], 1'b0};
			bits_left_q <= bits_left_q - LEN_W'(1);
		end
	end

	assign serial.valid       = bits_left_q != '0;
	assign serial.data_bit    = shift_q[FRAME_W-1];
	assign serial.last        = bits_left_q == LEN_W'(1);
	assign serial.range_error = err_q;

	`PLLSS_ASSERT(a_len_bound, bits_left_q <= LEN_W'(FRAME_W))
	`PLLSS_ASSERT_NEXT(a_load_len, in_valid && in_ready, bits_left_q == $past(in_frame.len))
	`PLLSS_ASSERT_NEXT(a_count_down, out_fire && !serial.last && !in_valid,
		bits_left_q == $past(bits_left_q) - LEN_W'(1))
	`PLLSS_ASSERT_NEXT(a_err_held, serial.valid && !serial.last,
		serial.range_error == $past(serial.range_error))
endmodule

### sv/pll_synth_serial_programmer_top.sv
// pll_synth_serial_programmer_top.sv: top level of the PLL synthesizer serial programmer.
// Depends on pllss_pkg, pllss_if, pllss_divq, pllss_frame and pllss_ser.
//
//   channel      | dir | handshake     | contents of one beat
//   -------------+-----+---------------+-----------------------------------------
//   cmd          | in  | valid / ready | command, value, a_count, b_count
//   serial       | out | valid / ready | data_bit, last, range_error
//   cfg_wr_*     | in  | enable only   | control_word, written when cfg_wr_en is high
//
// A command passes five register stages (four for the divide by 15000, one to
// build the frame) and is then loaded into the shifter. The shifter sends one
// bit per cycle while serial is ready, 8, 16 or 24 bits per command, so the shift
// register sets the sustained rate, and the next frame loads on the edge that
// takes the final bit. Reset clears all valid bits and the shifter
// and restores control_word to 0x6D. A stall on serial holds the current bit and
// backs up the stages one by one; up to five further commands wait in them.
module pll_synth_serial_programmer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	pllss_cmd_if.sink                     cmd,
	pllss_bit_if.source                   serial,
	input  logic                          cfg_wr_en,
	input  logic [pllss_pkg::CTRL_W-1:0]  cfg_wr_data
);
	import pllss_pkg::*;

	logic [CTRL_W-1:0] control_word_q;
	cmd_beat_t         in_beat;
	cmd_beat_t         div_beat;
	logic [Q_W-1:0]    div_quot;
	logic              div_valid, div_ready;
	frame_t            frame;
	logic              frame_valid, frame_ready;

	// The user must write the control byte only while no command is in flight; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_word_q <= CTRL_RESET;
		end else if (cfg_wr_en) begin
			control_word_q <= cfg_wr_data;
		end
	end

	assign in_beat.command = cmd_t'(cmd.command);
	assign in_beat.value   = cmd.value;
	assign in_beat.a_count = cmd.a_count;
	assign in_beat.b_count = cmd.b_count;

	// Quotient value / 15000 for the frequency command; the beat rides along.
	pllss_divq u_divq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.in_beat   (in_beat),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_beat  (div_beat),
		.out_quot  (div_quot)
	);

	// Frame select, saturation of R and B, and alignment to the shifter MSB.
	pllss_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.control_word (control_word_q),
		.in_valid     (div_valid),
		.in_ready     (div_ready),
		.in_beat      (div_beat),
		.in_quot      (div_quot),
		.out_valid    (frame_valid),
		.out_ready    (frame_ready),
		.out_frame    (frame)
	);

	// The shifter drives the serial channel straight from its registers.
	pllss_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame_valid),
		.in_ready (frame_ready),
		.in_frame (frame),
		.serial   (serial)
	);
endmodule

### sim/pllss_checker.sv
`timescale 1ns / 100ps
// pllss_checker.sv: watches the command, serial and control-word ports of the serial programmer.
// It predicts every serial beat and compares it. Depends on pllss_pkg and pllss_if.
module pllss_checker
	import pllss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	pllss_cmd_if              cmd,
	pllss_bit_if              serial,
	input  logic              cfg_wr_en,
	input  logic [CTRL_W-1:0] cfg_wr_data,
	output int                mismatches,
	output int                bits_owed
);

	localparam int unsigned STEP_HZ    = 15000;
	localparam int unsigned B_STEPS    = 64;
	localparam int unsigned HZ_PER_B   = STEP_HZ * B_STEPS;
	localparam int          REPORT_MAX = 10;

	typedef struct packed {
		logic data_bit;
		logic last;
		logic range_error;
	} serial_bit_t;

	logic [CTRL_W-1:0] ctrl_word;
	serial_bit_t       bits_due[$];

	// Builds the synthesizer frame for one command, right aligned in frame_t.bits.
	function automatic frame_t synth_frame(cmd_t c, logic [VALUE_W-1:0] v,
			logic [A_W-1:0] a, logic [B_W-1:0] b, logic [CTRL_W-1:0] ctrl);
		frame_t          f;
		logic [R_W-1:0]  r;
		logic [31:0]     b_full;
		logic [B_W-1:0]  b_sat;
		logic [A_W-1:0]  a_steps;
		f = '0;
		case (c)
			CMD_CONTROL: begin
				f.bits = FRAME_W'(ctrl);
				f.len  = LEN_CONTROL;
			end
			CMD_REF_DIV: begin
				f.err  = (v > VALUE_W'(R_MAX));
				r      = f.err ? R_MAX : v[R_W-1:0];
				f.bits = FRAME_W'(r | R_ENABLE);
				f.len  = LEN_REF_DIV;
			end
			CMD_FREQ: begin
				b_full  = v / HZ_PER_B;
				a_steps = A_W'((v % HZ_PER_B) / STEP_HZ);
				f.err   = (b_full > 32'(B_MAX));
				b_sat   = f.err ? B_MAX : b_full[B_W-1:0];
				f.bits  = {B_PREFIX, b_sat, a_steps};
				f.len   = LEN_AB;
			end
			default: begin
				f.bits = {B_PREFIX, b, a};
				f.len  = LEN_AB;
			end
		endcase
		return f;
	endfunction

	task automatic report(input string what, input serial_bit_t want, input serial_bit_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t pllss_checker: %s: expected data_bit=%0b last=%0b range_error=%0b, got data_bit=%0b last=%0b range_error=%0b",
				$time, what, want.data_bit, want.last, want.range_error,
				got.data_bit, got.last, got.range_error);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t      f;
		serial_bit_t got;
		serial_bit_t want;
		if (!arst_n) begin
			ctrl_word  = CTRL_RESET;
			bits_due.delete();
			mismatches = 0;
			bits_owed  = 0;
		end else begin
			if (serial.valid && serial.ready) begin
				got = '{serial.data_bit, serial.last, serial.range_error};
				if (bits_due.size() == 0) begin
					report("serial beat with nothing expected", '0, got);
				end else begin
					want = bits_due.pop_front();
					if (got.data_bit !== want.data_bit || got.last !== want.last ||
							got.range_error !== want.range_error)
						report("serial beat mismatch", want, got);
				end
			end
			if (cfg_wr_en)
				ctrl_word = cfg_wr_data;
			if (cmd.valid && cmd.ready) begin
				f = synth_frame(cmd_t'(cmd.command), cmd.value, cmd.a_count, cmd.b_count,
					ctrl_word);
				for (int i = int'(f.len) - 1; i >= 0; i--)
					bits_due.push_back('{f.bits[i], i == 0, f.err});
			end
			bits_owed = bits_due.size();
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// tb.sv: top of the serial programmer testbench, clock, reset, stimulus and verdict.
// Depends on pllss_pkg, pllss_if, the block's RTL and pllss_checker.
module tb;
	import pllss_pkg::*;

	localparam int CLK_HALF         = 4;
	localparam int RESET_CYCLES     = 11;
	// The longest quiet stretch of a correct run is the receiver hold-off plus
	// the five-stage pipeline; several times that is still far below the limit.
	localparam int QUIET_LIMIT      = 2000;
	localparam int HOLD_CYCLES      = 300;
	// The command path is five stages deep before the shifter; drain() waits this
	// long after the final beat so that the block is fully idle.
	localparam int SETTLE_CYCLES    = 12;
	localparam int RANDOM_PER_PHASE = 115;
	// Largest frequency whose B count still fits in 12 bits.
	localparam logic [VALUE_W-1:0] F_TOP = 32'd3932159999;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CTRL_W-1:0] cfg_wr_data;
	int                mismatches;
	int                bits_owed;
	bit                idle_on;
	bit                hold_start;
	bit                hold_done;

	pllss_cmd_if cmd ();
	pllss_bit_if serial ();

	pll_synth_serial_programmer_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.serial      (serial),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// The checker sees the same ports as the block and owns all prediction.
	pllss_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.serial      (serial),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mismatches  (mismatches),
		.bits_owed   (bits_owed)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Serial receiver. It drops ready at random while idling is enabled, and
	// once, on request, holds off for a long stretch so that the pipeline fills
	// and the command channel has to stall.
	initial begin : bit_sink
		serial.ready = 1'b0;
		hold_done    = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start && !hold_done) begin
				serial.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			serial.ready = !(idle_on && $urandom_range(0, 99) < 10);
		end
	end

	// Ends the run if no beat moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (serial.valid && serial.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[pll_synth_serial_programmer_top] ERROR");
		$finish;
	end

	// Offers one command beat and returns at the falling edge after it was taken.
	// Valid is left high so that a following call keeps the channel busy without
	// a bubble; drain() lowers it when a phase ends.
	task automatic send_cmd(input cmd_t c, input logic [VALUE_W-1:0] v,
			input logic [A_W-1:0] a, input logic [B_W-1:0] b);
		if (idle_on && $urandom_range(0, 99) < 10) begin
			cmd.valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		cmd.valid   = 1'b1;
		cmd.command = c;
		cmd.value   = v;
		cmd.a_count = a;
		cmd.b_count = b;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
	endtask

	// Stops offering commands and waits until every predicted beat has arrived
	// and the pipeline has had time to empty.
	task automatic drain();
		cmd.valid = 1'b0;
		while (bits_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The control word may only change while the block is idle.
	task automatic write_ctrl(input logic [CTRL_W-1:0] word);
		drain();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = word;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	// Random commands. Divider and frequency values are mostly in range, with
	// some just past the saturation point and some fully random 32-bit values.
	task automatic random_cmds(input int count);
		cmd_t              c;
		logic [VALUE_W-1:0] v;
		int                pick;
		repeat (count) begin
			c    = cmd_t'($urandom_range(0, 3));
			pick = $urandom_range(0, 9);
			case (c)
				CMD_REF_DIV: begin
					if (pick < 7)
						v = $urandom_range(0, 65535);
					else if (pick < 8)
						v = $urandom_range(65536, 70000);
					else
						v = $urandom();
				end
				CMD_FREQ: begin
					if (pick < 5)
						v = $urandom_range(0, F_TOP);
					else if (pick < 7)
						// Land exactly on, or just below, a 15 kHz step.
						v = $urandom_range(1, 262079) * 15000 - $urandom_range(0, 1);
					else if (pick < 8)
						v = F_TOP - 32 + $urandom_range(0, 63);
					else
						v = $urandom();
				end
				default: v = $urandom();
			endcase
			send_cmd(c, v, A_W'($urandom()), B_W'($urandom()));
		end
	endtask

	initial begin : stimulus
		cmd.valid   = 1'b0;
		cmd.command = CMD_CONTROL;
		cmd.value   = '0;
		cmd.a_count = '0;
		cmd.b_count = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		idle_on     = 1'b1;
		hold_start  = 1'b0;
		arst_n      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed commands with the control word at its reset value.
		send_cmd(CMD_CONTROL, '0, '0, '0);
		send_cmd(CMD_REF_DIV, 32'd0, '0, '0);
		send_cmd(CMD_REF_DIV, 32'h0000_2000, '0, '0);   // enable bit already set
		send_cmd(CMD_REF_DIV, 32'h0000_1234, '0, '0);
		send_cmd(CMD_REF_DIV, 32'h0000_FFFF, '0, '0);   // largest legal divider
		send_cmd(CMD_REF_DIV, 32'h0001_0000, '0, '0);   // first saturating divider
		send_cmd(CMD_REF_DIV, 32'hFFFF_FFFF, '0, '0);
		send_cmd(CMD_FREQ, 32'd0, '0, '0);
		send_cmd(CMD_FREQ, 32'd14999, '0, '0);
		send_cmd(CMD_FREQ, 32'd15000, '0, '0);
		send_cmd(CMD_FREQ, 32'd959999, '0, '0);         // A at its top, B still zero
		send_cmd(CMD_FREQ, 32'd960000, '0, '0);
		send_cmd(CMD_FREQ, F_TOP, '0, '0);              // B at 4095 without saturation
		send_cmd(CMD_FREQ, F_TOP + 1, '0, '0);          // B saturates
		send_cmd(CMD_FREQ, 32'hFFFF_FFFF, '0, '0);
		send_cmd(CMD_DIRECT, 32'hFFFF_FFFF, 8'h00, 12'h000);
		send_cmd(CMD_DIRECT, 32'h0000_0000, 8'hFF, 12'hFFF);
		send_cmd(CMD_DIRECT, 32'h5555_AAAA, 8'h5A, 12'hA5C);
		random_cmds(RANDOM_PER_PHASE);

		write_ctrl(8'h00);
		send_cmd(CMD_CONTROL, '0, '0, '0);
		random_cmds(RANDOM_PER_PHASE);

		// A long stretch with no idling on either side.
		write_ctrl(8'hFF);
		idle_on = 1'b0;
		random_cmds(RANDOM_PER_PHASE);
		idle_on = 1'b1;

		// The receiver holds off at the start of this phase while commands keep
		// coming, so the block backs up and stalls its command input.
		write_ctrl(CTRL_W'($urandom_range(1, 254)));
		hold_start = 1'b1;
		random_cmds(RANDOM_PER_PHASE);

		drain();
		if (mismatches == 0)
			$display("[pll_synth_serial_programmer_top] OK");
		else
			$display("[pll_synth_serial_programmer_top] ERROR");
		$finish;
	end

endmodule
